>>> src/lome_pkg.sv
// ----------------------------------------------------------------------------
// lome_pkg
// Shared types and constants of the limit order match engine.
// ----------------------------------------------------------------------------
package lome_pkg;

  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;
  localparam logic SIDE_BUY   = 1'b0;
  localparam logic SIDE_SELL  = 1'b1;

  typedef enum logic [2:0] {
    ST_RESTED    = 3'd0,
    ST_MATCHED   = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_DROPPED   = 3'd4
  } status_e;

  typedef struct packed {
    logic        command;
    logic [31:0] order_id;
    logic        side;
    logic [31:0] limit_price;
    logic [31:0] order_time;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] buy_id;
    logic [31:0] sell_id;
    logic [31:0] trade_price;
  } rsp_t;

  // One table entry as held in memory.
  typedef struct packed {
    logic [31:0] ident;
    logic [31:0] limit;
    logic [31:0] stamp;
    logic [31:0] arrival;
  } entry_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_LAST,
    FSM_WRITE,
    FSM_CANCEL2
  } fsm_e;

endpackage

>>> src/lome_ram.sv
// ----------------------------------------------------------------------------
// lome_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module lome_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/limit_order_match_engine.sv
// ----------------------------------------------------------------------------
// limit_order_match_engine
// Price-time priority matching over a buy table and a sell table in RAM.
// ----------------------------------------------------------------------------
// A transaction is taken when start_i is high and busy_o is low. Each
// transaction scans a table sequentially through a RAM read port, one entry
// per cycle: a submit scans the opposite table, a cancel scans the buy table
// and, if the id is not found there, goes on to scan the sell table.
// The result is shown on rsp_o for one cycle with done_o high; the receiver
// cannot stall it. Valid bits are flip-flops cleared by reset, so no clearing
// pass is needed.
module limit_order_match_engine
  import lome_pkg::*;
#(
  parameter int BOOK_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

  fsm_e state_q, state_d;
  req_t req_q;
  logic side_q;                     // table being scanned: 0 buy, 1 sell
  logic [AW-1:0] addr_q;
  logic [AW-1:0] rd_idx_q;          // index of data arriving this cycle
  logic [BOOK_DEPTH-1:0] bvalid_q, svalid_q;
  logic found_q;
  logic [AW-1:0] pick_q;
  entry_t pick_e_q;
  logic free_found_q;
  logic [AW-1:0] free_q;
  logic [31:0] arrival_q;

  entry_t rd_buy, rd_sell, rd_ent;
  logic we_buy, we_sell;
  entry_t wr_ent;

  lome_ram #(.Width($bits(entry_t)), .Depth(BOOK_DEPTH)) u_buy (
    .clk_i, .we_i(we_buy), .waddr_i(free_q), .wdata_i(wr_ent),
    .raddr_i(addr_q), .rdata_o(rd_buy)
  );
  lome_ram #(.Width($bits(entry_t)), .Depth(BOOK_DEPTH)) u_sell (
    .clk_i, .we_i(we_sell), .waddr_i(free_q), .wdata_i(wr_ent),
    .raddr_i(addr_q), .rdata_o(rd_sell)
  );

  assign rd_ent = side_q ? rd_sell : rd_buy;
  assign wr_ent = '{ident: req_q.order_id, limit: req_q.limit_price,
                    stamp: req_q.order_time, arrival: arrival_q};

  // Candidate evaluation for the entry read this cycle.
  logic rd_valid, cand, better, last_addr;
  always_comb begin
    rd_valid = side_q ? svalid_q[rd_idx_q] : bvalid_q[rd_idx_q];
    cand = 1'b0;
    better = 1'b0;
    if (req_q.command == CMD_CANCEL) begin
      cand = rd_valid && (rd_ent.ident == req_q.order_id);
      better = !found_q || (rd_ent.arrival < pick_e_q.arrival);
    end else if (side_q == SIDE_SELL) begin
      cand = rd_valid && (rd_ent.limit <= req_q.limit_price);
      better = !found_q || (rd_ent.limit < pick_e_q.limit) ||
               ((rd_ent.limit == pick_e_q.limit) &&
                ((rd_ent.stamp < pick_e_q.stamp) ||
                 ((rd_ent.stamp == pick_e_q.stamp) &&
                  (rd_ent.arrival < pick_e_q.arrival))));
    end else begin
      cand = rd_valid && (rd_ent.limit >= req_q.limit_price);
      better = !found_q || (rd_ent.limit > pick_e_q.limit) ||
               ((rd_ent.limit == pick_e_q.limit) &&
                ((rd_ent.stamp < pick_e_q.stamp) ||
                 ((rd_ent.stamp == pick_e_q.stamp) &&
                  (rd_ent.arrival < pick_e_q.arrival))));
    end
    last_addr = (addr_q == AW'(BOOK_DEPTH - 1));
  end

  // Read data is only meaningful once the first address of a pass has been
  // through the RAM, so the opening scan cycle is not evaluated.
  logic scanning;
  assign scanning = ((state_q == FSM_SCAN) && (addr_q != '0)) || (state_q == FSM_LAST);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE:    if (start_i) state_d = FSM_SCAN;
      FSM_SCAN:    if (last_addr) state_d = FSM_LAST;
      FSM_LAST:    state_d = FSM_WRITE;
      FSM_WRITE: begin
        if (req_q.command == CMD_CANCEL && !found_q && side_q == SIDE_BUY) begin
          state_d = FSM_CANCEL2;
        end else begin
          state_d = FSM_IDLE;
        end
      end
      FSM_CANCEL2: state_d = FSM_SCAN;
      default:     state_d = FSM_IDLE;
    endcase
  end

  // Output and write decode.
  logic finish, rest_ok;
  always_comb begin
    finish = (state_q == FSM_WRITE) && (state_d == FSM_IDLE);
    rest_ok = (req_q.command == CMD_SUBMIT) && !found_q && free_found_q;
    we_buy  = finish && rest_ok && (req_q.side == SIDE_BUY);
    we_sell = finish && rest_ok && (req_q.side == SIDE_SELL);
    busy_o  = (state_q != FSM_IDLE);
  end

  // Response formed from the outcome of the scan.
  rsp_t rsp_d;
  always_comb begin
    rsp_d = '0;
    if (req_q.command == CMD_CANCEL) begin
      rsp_d.status = found_q ? ST_CANCELLED : ST_NOTFOUND;
    end else if (found_q) begin
      rsp_d.status      = ST_MATCHED;
      rsp_d.trade_price = pick_e_q.limit;
      rsp_d.buy_id  = (req_q.side == SIDE_BUY) ? req_q.order_id : pick_e_q.ident;
      rsp_d.sell_id = (req_q.side == SIDE_BUY) ? pick_e_q.ident : req_q.order_id;
    end else begin
      rsp_d.status = free_found_q ? ST_RESTED : ST_DROPPED;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      bvalid_q  <= '0;
      svalid_q  <= '0;
      arrival_q <= '0;
      done_o    <= 1'b0;
      addr_q    <= '0;
      found_q   <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= finish;
      if (state_q == FSM_IDLE && start_i) begin
        addr_q  <= '0;
        found_q <= 1'b0;
        free_found_q <= 1'b0;
      end else if (state_q == FSM_CANCEL2) begin
        addr_q  <= '0;
        found_q <= 1'b0;
      end else if (state_q == FSM_SCAN && !last_addr) begin
        addr_q <= addr_q + AW'(1);
      end
      if (scanning && cand && better) found_q <= 1'b1;
      // Lowest free slot of the order's own table, for resting.
      if (scanning && !free_found_q) begin
        if (req_q.side == SIDE_BUY ? !bvalid_q[rd_idx_q] : !svalid_q[rd_idx_q]) begin
          free_found_q <= 1'b1;
        end
      end
      if (finish) begin
        if (found_q) begin
          if (side_q) svalid_q[pick_q] <= 1'b0;
          else        bvalid_q[pick_q] <= 1'b0;
        end else if (rest_ok) begin
          if (req_q.side == SIDE_SELL) svalid_q[free_q] <= 1'b1;
          else                         bvalid_q[free_q] <= 1'b1;
          arrival_q <= arrival_q + 32'd1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    if (state_q == FSM_IDLE && start_i) begin
      req_q  <= start_i ? req_i : req_q;
      side_q <= (req_i.command == CMD_CANCEL) ? SIDE_BUY : ~req_i.side;
    end else if (state_q == FSM_CANCEL2) begin
      side_q <= SIDE_SELL;
    end
    if (scanning && cand && better) begin
      pick_q   <= rd_idx_q;
      pick_e_q <= rd_ent;
    end
    if (scanning && !free_found_q) begin
      free_q <= rd_idx_q;
    end
    if (finish) begin
      rsp_o <= rsp_d;
    end
  end

  // Checks.
  a_done_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == FSM_WRITE)) else $error("done without write");
  a_busy_while_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scanning |-> busy_o) else $error("scan while not busy");
  a_no_double_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we_buy && we_sell)) else $error("both tables written");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held over two cycles");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the limit order match engine. Submit and
// cancel transactions are driven with random gaps; a scoreboard keeps its own
// buy and sell books, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lome_pkg::*;

  localparam int DEPTH     = 64;
  localparam int NUM_RAND  = 1200;
  localparam int WDOG_MAX  = 20000;

  // Price-time priority book model with a queue of predicted responses.
  class book_scoreboard;
    bit          bvalid [DEPTH];
    logic [31:0] bident [DEPTH];
    logic [31:0] blimit [DEPTH];
    logic [31:0] bstamp [DEPTH];
    logic [31:0] barr   [DEPTH];
    bit          svalid [DEPTH];
    logic [31:0] sident [DEPTH];
    logic [31:0] slimit [DEPTH];
    logic [31:0] sstamp [DEPTH];
    logic [31:0] sarr   [DEPTH];
    logic [31:0] arrival_cnt;
    rsp_t        pending_rsp [$];
    int          errors;
    int          n_match;
    int          n_cancel;
    int          n_drop;

    function void clear_books();
      foreach (bvalid[i]) begin
        bvalid[i] = 0;
        svalid[i] = 0;
      end
      arrival_cnt = '0;
      errors = 0;
    endfunction

    // Takes the earliest-arriving entry carrying the id out of one side.
    function bit cancel_side(bit sell, logic [31:0] id);
      int pick;
      pick = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (sell) begin
          if (svalid[i] && sident[i] == id && (pick < 0 || sarr[i] < sarr[pick]))
            pick = i;
        end else begin
          if (bvalid[i] && bident[i] == id && (pick < 0 || barr[i] < barr[pick]))
            pick = i;
        end
      end
      if (pick < 0) return 0;
      if (sell) svalid[pick] = 0;
      else bvalid[pick] = 0;
      return 1;
    endfunction

    // Places the order in the lowest free slot of its own side.
    function logic [2:0] rest_order(req_t r);
      for (int i = 0; i < DEPTH; i++) begin
        if (r.side == SIDE_BUY && !bvalid[i]) begin
          bvalid[i] = 1; bident[i] = r.order_id; blimit[i] = r.limit_price;
          bstamp[i] = r.order_time; barr[i] = arrival_cnt;
          arrival_cnt++;
          return ST_RESTED;
        end
        if (r.side == SIDE_SELL && !svalid[i]) begin
          svalid[i] = 1; sident[i] = r.order_id; slimit[i] = r.limit_price;
          sstamp[i] = r.order_time; sarr[i] = arrival_cnt;
          arrival_cnt++;
          return ST_RESTED;
        end
      end
      return ST_DROPPED;
    endfunction

    // Notes an accepted transaction and queues the response it must give.
    function void note_request(req_t r);
      rsp_t e;
      int   pick;
      bit   better;
      e = '0;
      pick = -1;
      if (r.command == CMD_CANCEL) begin
        if (cancel_side(0, r.order_id) || cancel_side(1, r.order_id)) begin
          e.status = ST_CANCELLED;
          n_cancel++;
        end else e.status = ST_NOTFOUND;
      end else if (r.side == SIDE_BUY) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!svalid[i] || slimit[i] > r.limit_price) continue;
          better = pick < 0 || slimit[i] < slimit[pick] ||
                   (slimit[i] == slimit[pick] && (sstamp[i] < sstamp[pick] ||
                    (sstamp[i] == sstamp[pick] && sarr[i] < sarr[pick])));
          if (better) pick = i;
        end
        if (pick >= 0) begin
          svalid[pick] = 0;
          e.status = ST_MATCHED; e.buy_id = r.order_id;
          e.sell_id = sident[pick]; e.trade_price = slimit[pick];
        end else e.status = rest_order(r);
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!bvalid[i] || blimit[i] < r.limit_price) continue;
          better = pick < 0 || blimit[i] > blimit[pick] ||
                   (blimit[i] == blimit[pick] && (bstamp[i] < bstamp[pick] ||
                    (bstamp[i] == bstamp[pick] && barr[i] < barr[pick])));
          if (better) pick = i;
        end
        if (pick >= 0) begin
          bvalid[pick] = 0;
          e.status = ST_MATCHED; e.buy_id = bident[pick];
          e.sell_id = r.order_id; e.trade_price = blimit[pick];
        end else e.status = rest_order(r);
      end
      if (e.status == ST_MATCHED) n_match++;
      if (e.status == ST_DROPPED) n_drop++;
      pending_rsp.push_back(e);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", what, got, want, $time);
      errors++;
    endtask

    // Compares one response with the oldest prediction.
    task check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response status", 32'(got.status), 32'd0);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.buy_id !== want.buy_id) report_mismatch("buy_id", got.buy_id, want.buy_id);
      if (got.sell_id !== want.sell_id) report_mismatch("sell_id", got.sell_id, want.sell_id);
      if (got.trade_price !== want.trade_price)
        report_mismatch("trade_price", got.trade_price, want.trade_price);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  book_scoreboard book_sb;
  int             idle_cycles = 0;
  logic [31:0]    used_ids [$];

  limit_order_match_engine #(.BOOK_DEPTH(DEPTH)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watches accepted transactions and responses; the watchdog rides along.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) book_sb.note_request(req_i);
      if (done_o) book_sb.check_response(rsp_o);
      if ((start_i && !busy_o) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("Watchdog expired after %0d idle cycles", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Random gap: mostly none or short, now and then long. The request is only
  // withdrawn when there is a gap, so a back-to-back transaction replaces it.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 150);
    if (n > 0) begin
      start_i <= 1'b0;
      req_i   <= '0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drives one transaction and holds it until the engine takes it.
  task automatic send_request(req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    idle_gap();
  endtask

  task automatic send_order(logic sd, logic [31:0] id, logic [31:0] px, logic [31:0] ts);
    req_t r;
    r = '0;
    r.command = CMD_SUBMIT; r.side = sd; r.order_id = id;
    r.limit_price = px; r.order_time = ts;
    used_ids.push_back(id);
    send_request(r);
  endtask

  task automatic send_cancel(logic [31:0] id);
    req_t r;
    r = '0;
    r.command = CMD_CANCEL; r.order_id = id;
    r.side = 1'($urandom_range(0, 1)); r.limit_price = $urandom; r.order_time = $urandom;
    send_request(r);
  endtask

  // Well-formed book traffic: prices near a mid so orders cross and rest, full range in mode 1.
  task automatic random_item(int mode);
    logic [31:0] id;
    logic [31:0] px;
    int          pick;
    pick = $urandom_range(0, 99);
    if (mode == 1) px = $urandom;
    else px = 1000 + $urandom_range(0, 40) - 20;
    if (pick < 20) begin
      if (used_ids.size() > 0 && $urandom_range(0, 3) != 0)
        id = used_ids[$urandom_range(0, used_ids.size() - 1)];
      else id = $urandom;
      send_cancel(id);
    end else begin
      id = ($urandom_range(0, 3) == 0 && used_ids.size() > 0) ?
           used_ids[$urandom_range(0, used_ids.size() - 1)] : $urandom;
      send_order(1'($urandom_range(0, 1)), id, px,
                 (mode == 2) ? $urandom : $urandom_range(0, 7));
    end
    if (used_ids.size() > 200) void'(used_ids.pop_front());
  endtask

  initial begin
    int waited;
    book_sb = new();
    book_sb.clear_books();
    start_i = 1'b0;
    req_i   = '0;
    rst_ni  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty book, extremes, ties on price and time, cancels.
    send_cancel(32'h0);
    send_order(SIDE_BUY, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_order(SIDE_SELL, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(SIDE_SELL, 32'h2, 32'h0, 32'h5);
    send_order(SIDE_BUY, 32'h10, 32'd100, 32'd7);
    send_order(SIDE_BUY, 32'h11, 32'd100, 32'd3);
    send_order(SIDE_BUY, 32'h12, 32'd100, 32'd3);
    send_order(SIDE_SELL, 32'h20, 32'd90, 32'd0);
    send_order(SIDE_SELL, 32'h21, 32'd100, 32'd0);
    send_order(SIDE_BUY, 32'h30, 32'hFFFF_FFFF, 32'h0);
    send_order(SIDE_BUY, 32'h40, 32'd50, 32'd1);
    send_order(SIDE_SELL, 32'h40, 32'd60, 32'd1);
    send_cancel(32'h40);
    send_cancel(32'h40);
    send_cancel(32'h40);
    send_cancel(32'hFFFF_FFFF);
    send_cancel(32'h1);

    // Fill the buy side past its depth so the overflow drop is seen.
    for (int i = 0; i < DEPTH + 3; i++) send_order(SIDE_BUY, 32'h100 + i, 32'd5, i);
    send_order(SIDE_SELL, 32'h200, 32'd5, 32'd0);
    for (int i = 0; i < DEPTH + 3; i++) send_cancel(32'h100 + i);

    // Random traffic, mostly crossing prices and some full-range noise.
    for (int i = 0; i < NUM_RAND; i++)
      random_item((i % 10 == 9) ? 1 : ((i % 7 == 3) ? 2 : 0));
    start_i <= 1'b0;
    req_i   <= '0;

    waited = 0;
    while (book_sb.pending_rsp.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (2 * DEPTH + 10) @(posedge clk_i);

    $display("Covered %0d trades, %0d cancels and %0d dropped orders.",
             book_sb.n_match, book_sb.n_cancel, book_sb.n_drop);
    if (book_sb.pending_rsp.size() != 0) begin
      $display("%0d responses never arrived", book_sb.pending_rsp.size());
      book_sb.errors++;
    end
    if (book_sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
